// ----- src/aud_pkg.sv -----
// Package for the array union dedup block: word types and shared constants.
// No dependencies; every module of the block imports it.
package aud_pkg;

  // Generation tag kept next to each stored value; zero marks an empty slot.
  localparam int unsigned EPOCH_BITS = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  localparam logic [7:0] DUP_MAX = 8'hFF;

  typedef struct packed {
    logic        row_start;
    logic [63:0] elem_value;
    logic        elem_is_null;
  } aud_in_t;

  typedef struct packed {
    logic        keep;
    logic [63:0] out_value;
    logic        out_is_null;
    logic [7:0]  dup_count;
    logic        set_overflow;
  } aud_out_t;

endpackage

// ----- src/aud_set_mem.sv -----
// Single-port-write, single-port-read synchronous RAM holding the value set.
// Registered read data. Uses aud_pkg only by convention.
module aud_set_mem
  import aud_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 72
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/aud_hash.sv -----
// Home-slot hash for the value set: XOR fold of the value into an index
// below SET_DEPTH. Depends on aud_pkg.
module aud_hash
  import aud_pkg::*;
#(
  parameter int unsigned SET_DEPTH  = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic [VALUE_BITS-1:0]        value_i,
  output logic [$clog2(SET_DEPTH)-1:0] index_o
);

  localparam int unsigned AW = $clog2(SET_DEPTH);

  logic [AW-1:0] fold;

  always_comb begin
    fold = '0;
    for (int unsigned i = 0; i < VALUE_BITS; i++) begin
      fold[i % AW] = fold[i % AW] ^ value_i[i];
    end
  end

  // non power-of-two depth: fold < 2*SET_DEPTH, so one subtract wraps it
  always_comb begin
    if ({1'b0, fold} >= (AW+1)'(SET_DEPTH)) begin
      index_o = fold - AW'(SET_DEPTH);
    end else begin
      index_o = fold;
    end
  end

endmodule

// ----- src/array_union_dedup.sv -----
// Distinct filter over a stream of array elements, one result word per input
// word. Values live in an open-addressed hash table (linear probing) in one
// synchronous RAM, each slot tagged with a row generation so a row start
// empties the set at once. A non-null value probes from its home slot until
// it finds a free or matching slot, or until every slot has been probed when
// the set is full; a null skips the table. Probing reads one slot per cycle
// through the RAM's single read port. After reset, and on every 255th row
// start when the generation tag wraps, the block sweeps every RAM slot with
// in_ready_o low. Depends on aud_pkg, aud_hash and aud_set_mem.
module array_union_dedup
  import aud_pkg::*;
#(
  parameter int unsigned SET_DEPTH  = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aud_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aud_out_t out_data_o
);

  localparam int unsigned AW = $clog2(SET_DEPTH);
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam int unsigned EW = EPOCH_BITS + VALUE_BITS;

  localparam logic [AW-1:0] LAST_ADDR = AW'(SET_DEPTH - 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(SET_DEPTH);

  localparam logic [2:0] ST_WIPE  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         wipe_addr_q, wipe_addr_d;
  logic                  pend_q, pend_d;
  logic [EPOCH_BITS-1:0] epoch_q, epoch_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic                  null_seen_q, null_seen_d;
  logic [7:0]            drop_q, drop_d;
  logic                  out_valid_q, out_valid_d;

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  is_null_q, is_null_d;
  logic [AW-1:0]         probe_addr_q, probe_addr_d;
  logic [AW-1:0]         probe_cnt_q, probe_cnt_d;
  aud_out_t              res_q, res_d;
  aud_out_t              out_q, out_d;

  logic [AW-1:0]         hash_idx;
  logic [AW-1:0]         next_addr;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [EW-1:0]         mem_wdata, mem_rdata;
  logic [EPOCH_BITS-1:0] rd_epoch;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  slot_live, slot_hit;
  logic                  in_fire, out_free;
  logic                  base_null;
  logic [7:0]            base_drop;
  logic [7:0]            drop_inc;

  aud_hash #(
    .SET_DEPTH  (SET_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_hash (
    .value_i (in_data_i.elem_value[VALUE_BITS-1:0]),
    .index_o (hash_idx)
  );

  aud_set_mem #(
    .DEPTH (SET_DEPTH),
    .WIDTH (EW)
  ) u_set_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  assign rd_epoch  = mem_rdata[EW-1:VALUE_BITS];
  assign rd_val    = mem_rdata[VALUE_BITS-1:0];
  assign slot_live = (rd_epoch == epoch_q);
  assign slot_hit  = slot_live && (rd_val == val_q);
  assign next_addr = (probe_addr_q == LAST_ADDR) ? '0 : probe_addr_q + 1'b1;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign base_null = in_data_i.row_start ? 1'b0 : null_seen_q;
  assign base_drop = in_data_i.row_start ? 8'd0 : drop_q;
  assign drop_inc  = (drop_q == DUP_MAX) ? drop_q : drop_q + 8'd1;

  // RAM port steering
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = probe_addr_q;
    mem_we    = 1'b0;
    mem_waddr = probe_addr_q;
    mem_wdata = {epoch_q, val_q};
    case (state_q)
      ST_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = wipe_addr_q;
        mem_wdata = '0;
      end
      ST_ISSUE: begin
        mem_re = 1'b1;
      end
      ST_PROBE: begin
        if (!slot_hit && !slot_live) begin
          mem_we = 1'b1;
        end else if (!slot_hit && probe_cnt_q != LAST_ADDR) begin
          mem_re    = 1'b1;
          mem_raddr = next_addr;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    wipe_addr_d  = wipe_addr_q;
    pend_d       = pend_q;
    epoch_d      = epoch_q;
    fill_d       = fill_q;
    null_seen_d  = null_seen_q;
    drop_d       = drop_q;
    val_d        = val_q;
    is_null_d    = is_null_q;
    probe_addr_d = probe_addr_q;
    probe_cnt_d  = probe_cnt_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_WIPE: begin
        if (wipe_addr_q == LAST_ADDR) begin
          wipe_addr_d = '0;
          epoch_d     = EPOCH_FIRST;
          pend_d      = 1'b0;
          if (!pend_q) begin
            state_d = ST_IDLE;
          end else if (is_null_q) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_ISSUE;
          end
        end else begin
          wipe_addr_d = wipe_addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          val_d        = in_data_i.elem_value[VALUE_BITS-1:0];
          is_null_d    = in_data_i.elem_is_null;
          probe_addr_d = hash_idx;
          probe_cnt_d  = '0;
          null_seen_d  = base_null;
          drop_d       = base_drop;
          if (in_data_i.row_start) begin
            fill_d = '0;
          end

          res_d.keep         = 1'b0;
          res_d.out_value    = '0;
          res_d.out_is_null  = 1'b0;
          res_d.dup_count    = base_drop;
          res_d.set_overflow = 1'b0;
          if (in_data_i.elem_is_null) begin
            null_seen_d = 1'b1;
            if (!base_null) begin
              res_d.keep        = 1'b1;
              res_d.out_is_null = 1'b1;
            end else begin
              drop_d          = (base_drop == DUP_MAX) ? base_drop : base_drop + 8'd1;
              res_d.dup_count = drop_d;
            end
          end

          // tag wrap: old entries could alias the new generation, sweep first
          if (in_data_i.row_start && epoch_q == EPOCH_LAST) begin
            state_d     = ST_WIPE;
            pend_d      = 1'b1;
            wipe_addr_d = '0;
          end else begin
            if (in_data_i.row_start) begin
              epoch_d = epoch_q + 1'b1;
            end
            state_d = in_data_i.elem_is_null ? ST_EMIT : ST_ISSUE;
          end
        end
      end

      ST_ISSUE: begin
        state_d = ST_PROBE;
      end

      ST_PROBE: begin
        res_d.out_value    = 64'(val_q);
        res_d.out_is_null  = 1'b0;
        res_d.set_overflow = 1'b0;
        res_d.dup_count    = drop_q;
        if (slot_hit) begin
          res_d.keep      = 1'b0;
          drop_d          = drop_inc;
          res_d.dup_count = drop_inc;
          state_d         = ST_EMIT;
        end else if (!slot_live) begin
          res_d.keep = 1'b1;
          fill_d     = fill_q + 1'b1;
          state_d    = ST_EMIT;
        end else if (probe_cnt_q == LAST_ADDR) begin
          // every slot holds another value of this row
          res_d.keep         = 1'b1;
          res_d.set_overflow = 1'b1;
          state_d            = ST_EMIT;
        end else begin
          probe_addr_d = next_addr;
          probe_cnt_d  = probe_cnt_q + 1'b1;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      wipe_addr_q <= '0;
      pend_q      <= 1'b0;
      epoch_q     <= EPOCH_FIRST;
      fill_q      <= '0;
      null_seen_q <= 1'b0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      is_null_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      wipe_addr_q <= wipe_addr_d;
      pend_q      <= pend_d;
      epoch_q     <= epoch_d;
      fill_q      <= fill_d;
      null_seen_q <= null_seen_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      is_null_q   <= is_null_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    probe_addr_q <= probe_addr_d;
    probe_cnt_q  <= probe_cnt_d;
    res_q        <= res_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("set fill count above depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("set RAM read and write to one slot in one cycle");

  a_ovf_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && res_q.set_overflow) |-> (fill_q == FILL_FULL))
    else $error("overflow reported with free slots");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("generation tag collides with empty marker");

  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE && mem_we) |-> (fill_q != FILL_FULL))
    else $error("insert into a full set");
`endif

endmodule
